FILE: design/twcr_pkg.sv
// Shared types, constants, texture table and shading function for the column rasterizer.
package twcr_pkg;

    // Field widths fixed by the interface.
    localparam int COLUMN_W = 7;
    localparam int HEIGHT_W = 11;
    localparam int TEXROW_W = 4;
    localparam int HALF_W   = HEIGHT_W - 1;

    // Texture geometry: 16 texels per row, 16 rows.
    localparam int TEX_SIZE   = 16;
    localparam int TEX_LOG    = 4;
    localparam int ADDR_W     = 8;
    localparam int ROM_DEPTH  = 256;
    localparam logic [ADDR_W-1:0] ADDR_MAX = ADDR_W'(ROM_DEPTH - 1);

    // Error accumulator: holds values from -15 up to below the largest height.
    localparam int ERR_W    = 12;
    localparam int ERR_STEP = 15;

    // Texel codes.
    localparam logic [1:0] TEX_SOLID = 2'd0;
    localparam logic [1:0] TEX_PLAIN = 2'd1;
    localparam logic [1:0] TEX_CHECK = 2'd2;
    localparam logic [1:0] TEX_DOTS  = 2'd3;

    // Fixed texture codes, row-major, 16 texels per row.
    localparam logic [1:0] TEX_ROM [ROM_DEPTH] = '{
        0,2,1,1,1,0,2,1,1,1,0,2,3,3,3,0,
        0,2,1,1,1,0,2,1,1,1,0,2,3,3,3,0,
        0,2,1,1,1,0,2,1,1,1,0,0,0,0,0,0,
        0,0,0,0,0,0,2,1,1,1,0,2,1,1,1,0,
        0,2,3,3,3,0,2,1,1,1,0,2,1,1,1,0,
        0,2,3,3,3,0,2,1,1,1,0,2,1,1,1,0,
        0,2,3,3,3,0,2,1,1,1,0,2,1,1,1,0,
        0,2,3,3,3,0,2,1,1,1,0,2,1,1,1,0,
        0,2,3,3,3,0,0,0,0,0,0,2,1,1,1,0,
        0,2,3,3,3,0,2,1,1,1,0,2,1,1,1,0,
        0,2,3,3,3,0,2,1,1,1,0,0,0,0,0,0,
        0,2,3,3,3,0,2,1,1,1,0,2,3,3,3,0,
        0,0,0,0,0,0,2,1,1,1,0,2,3,3,3,0,
        0,2,1,1,1,0,2,1,1,1,0,2,3,3,3,0,
        0,2,1,1,1,0,2,1,1,1,0,2,3,3,3,0,
        0,2,1,1,1,0,0,0,0,0,0,2,3,3,3,0
    };

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROW,
        ST_ADV
    } t_state;

    // Operations of the shared accumulator adder.
    typedef enum logic {
        ALU_STEP,
        ALU_ADV
    } t_alu_op;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic vis;
        logic is_last;
        logic alu_neg;
        logic out_free;
    } t_status;

    // Controls from the sequencer to the datapath.
    typedef struct packed {
        logic    in_ready;
        logic    load;
        logic    row_go;
        logic    emit;
        logic    adv_go;
        t_alu_op alu_op;
    } t_ctrl;

    // Pixel color from a texel code and the low bits of column and row.
    function automatic logic shade(input logic [1:0] code, input logic xbit,
                                   input logic ybit);
        logic pix;
        case (code)
            TEX_SOLID: pix = 1'b0;
            TEX_PLAIN: pix = 1'b1;
            TEX_CHECK: pix = xbit ^ ybit;
            TEX_DOTS:  pix = ~(xbit & ybit);
            default:   pix = 1'b1;
        endcase
        return pix;
    endfunction

endpackage

FILE: design/twcr_alu.sv
// Shared accumulator adder: takes the row step off or adds the height back.
module twcr_alu (
    input  twcr_pkg::t_alu_op                   i_op,
    input  logic signed [twcr_pkg::ERR_W-1:0]   i_verr,
    input  logic [twcr_pkg::HEIGHT_W-1:0]       i_height,
    output logic signed [twcr_pkg::ERR_W-1:0]   o_sum
);

    logic signed [twcr_pkg::ERR_W-1:0] operand;

    // Pick the second operand for the current step.
    always_comb begin
        case (i_op)
            twcr_pkg::ALU_STEP: operand = -twcr_pkg::ERR_W'(twcr_pkg::ERR_STEP);
            twcr_pkg::ALU_ADV:  operand = $signed({{(twcr_pkg::ERR_W -
                                          twcr_pkg::HEIGHT_W){1'b0}}, i_height});
            default:            operand = '0;
        endcase
    end

    assign o_sum = i_verr + operand;

endmodule

FILE: design/twcr_ctrl.sv
// Sequencer that walks the rows of one column and the texel advances between them.
module twcr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  twcr_pkg::t_status i_status,
    output twcr_pkg::t_ctrl   o_ctrl,
    output twcr_pkg::t_state  o_state
);

    twcr_pkg::t_state r_state;
    twcr_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= twcr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            twcr_pkg::ST_IDLE: begin
                if (i_status.in_valid) begin
                    n_state = twcr_pkg::ST_ROW;
                end
            end
            twcr_pkg::ST_ROW: begin
                if (!i_status.vis || i_status.out_free) begin
                    if (i_status.is_last) begin
                        n_state = twcr_pkg::ST_IDLE;
                    end else if (i_status.alu_neg) begin
                        n_state = twcr_pkg::ST_ADV;
                    end
                end
            end
            twcr_pkg::ST_ADV: begin
                if (!i_status.alu_neg) begin
                    n_state = twcr_pkg::ST_ROW;
                end
            end
            default: n_state = twcr_pkg::ST_IDLE;
        endcase
    end

    // Outputs decoded from the state and the datapath status.
    always_comb begin
        o_ctrl = '0;
        o_ctrl.alu_op = twcr_pkg::ALU_STEP;
        case (r_state)
            twcr_pkg::ST_IDLE: begin
                o_ctrl.in_ready = 1'b1;
                o_ctrl.load     = i_status.in_valid;
            end
            twcr_pkg::ST_ROW: begin
                o_ctrl.row_go = !i_status.vis || i_status.out_free;
                o_ctrl.emit   = i_status.vis && i_status.out_free;
            end
            twcr_pkg::ST_ADV: begin
                o_ctrl.adv_go = 1'b1;
                o_ctrl.alu_op = twcr_pkg::ALU_ADV;
            end
            default: o_ctrl = '0;
        endcase
    end

    assign o_state = r_state;

endmodule

FILE: design/textured_wall_column_rasterizer_top.sv
// Top level of the textured wall column rasterizer: datapath, output register, checks.
// The first pixel beat of a column follows its column beat through the column registers
// and the output register, later by each row above the screen and each texel advance before
// it, and by any stall of the output register. A new column is accepted only in idle, once
// the last row of the previous one is stepped; rows and texel advances share one adder.
// Reset (synchronous, active low) returns the sequencer to idle and empties the output.
module textured_wall_column_rasterizer_top #(
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [twcr_pkg::COLUMN_W-1:0]       i_column,
    input  logic [twcr_pkg::HEIGHT_W-1:0]       i_height,
    input  logic [twcr_pkg::TEXROW_W-1:0]       i_tex_row,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [$clog2(SCREEN_HEIGHT)-1:0]    o_row,
    output logic                                o_pixel_value,
    output logic                                o_last
);

    localparam int ROW_W = $clog2(SCREEN_HEIGHT);
    localparam int Y_W   = $clog2(SCREEN_HEIGHT / 2 + (1 << twcr_pkg::HALF_W)) + 1;
    localparam logic signed [Y_W-1:0] Y_MID = Y_W'(SCREEN_HEIGHT / 2);
    localparam logic signed [Y_W-1:0] Y_LIM = Y_W'(SCREEN_HEIGHT - 1);

    twcr_pkg::t_ctrl   ctrl;
    twcr_pkg::t_status status;
    twcr_pkg::t_state  state;

    logic                                 r_xbit;
    logic [twcr_pkg::HEIGHT_W-1:0]        r_w;
    logic [twcr_pkg::ADDR_W-1:0]          r_addr;
    logic signed [Y_W-1:0]                r_y;
    logic signed [Y_W-1:0]                r_ylast;
    logic signed [twcr_pkg::ERR_W-1:0]    r_verr;
    logic                                 r_out_valid;
    logic [ROW_W-1:0]                     r_out_row;
    logic                                 r_out_pix;
    logic                                 r_out_last;

    logic                                 n_out_valid;
    logic [twcr_pkg::HEIGHT_W-1:0]        in_w;
    logic [twcr_pkg::HALF_W-1:0]          in_half;
    logic signed [Y_W-1:0]                half_y;
    logic signed [Y_W-1:0]                y_bot;
    logic signed [twcr_pkg::ERR_W-1:0]    alu_sum;
    logic [twcr_pkg::ADDR_W-1:0]          addr_inc;
    logic [1:0]                           texel;

    // Column setup: zero height counts as one, span clipped to the bottom row.
    assign in_w    = (i_height == '0) ? twcr_pkg::HEIGHT_W'(1) : i_height;
    assign in_half = in_w[twcr_pkg::HEIGHT_W-1:1];
    assign half_y  = $signed({{(Y_W - twcr_pkg::HALF_W){1'b0}}, in_half});
    assign y_bot   = Y_MID + half_y;

    // Shared accumulator adder.
    twcr_alu u_alu (
        .i_op     (ctrl.alu_op),
        .i_verr   (r_verr),
        .i_height (r_w),
        .o_sum    (alu_sum)
    );

    // Sequencer.
    twcr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl),
        .o_state  (state)
    );

    // Status back to the sequencer.
    always_comb begin
        status.in_valid = i_in_valid;
        status.vis      = !r_y[Y_W-1];
        status.is_last  = (r_y == r_ylast);
        status.alu_neg  = alu_sum[twcr_pkg::ERR_W-1];
        status.out_free = !r_out_valid || i_out_ready;
    end

    // Texel lookup and saturating address step.
    assign texel    = twcr_pkg::TEX_ROM[r_addr];
    assign addr_inc = (r_addr == twcr_pkg::ADDR_MAX) ? r_addr : r_addr + 1'b1;

    // Column registers: loaded on accept, stepped per row and per texel advance.
    always_ff @(posedge i_clk) begin
        if (ctrl.load) begin
            r_xbit  <= i_column[0];
            r_w     <= in_w;
            r_addr  <= {i_tex_row, {twcr_pkg::TEX_LOG{1'b0}}};
            r_y     <= Y_MID - half_y;
            r_ylast <= (y_bot < Y_LIM) ? y_bot : Y_LIM;
            r_verr  <= $signed({{(twcr_pkg::ERR_W - twcr_pkg::HALF_W){1'b0}}, in_half});
        end else if (ctrl.row_go) begin
            r_y    <= r_y + Y_W'(1);
            r_verr <= alu_sum;
        end else if (ctrl.adv_go) begin
            r_verr <= alu_sum;
            r_addr <= addr_inc;
        end
    end

    // Output register valid: set on an emitted row, cleared when the beat is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (ctrl.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (ctrl.emit) begin
            r_out_row  <= r_y[ROW_W-1:0];
            r_out_pix  <= twcr_pkg::shade(texel, r_xbit, r_y[0]);
            r_out_last <= status.is_last;
        end
    end

    assign o_in_ready    = ctrl.in_ready;
    assign o_out_valid   = r_out_valid;
    assign o_row         = r_out_row;
    assign o_pixel_value = r_out_pix;
    assign o_last        = r_out_last;

`ifndef ASSERT_OFF
    // Only rows on the screen produce a pixel beat.
    a_emit_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.emit |-> !r_y[Y_W-1])
        else $error("pixel emitted for a row above the screen");

    // Texel advances happen only while the accumulator is negative.
    a_adv_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (state == twcr_pkg::ST_ADV) |-> r_verr[twcr_pkg::ERR_W-1])
        else $error("texel advance with a non-negative accumulator");

    // Row stepping always starts from a recovered accumulator.
    a_row_recovered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (state == twcr_pkg::ST_ROW) |-> !r_verr[twcr_pkg::ERR_W-1])
        else $error("row step with a negative accumulator");

    // The last pixel beat of a column returns the sequencer to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.emit && status.is_last) |=> (state == twcr_pkg::ST_IDLE))
        else $error("sequencer did not return to idle after the last pixel");

    // The texel address never moves backward within a column.
    a_addr_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (state == twcr_pkg::ST_ADV) |=> (r_addr >= $past(r_addr)))
        else $error("texel address moved backward");
`endif

endmodule
